// ===== hdl/tpt_pkg.sv =====
// Shared types, constants and helper functions of the touchpad pointer tracker.
package tpt_pkg;

    localparam int PAD_W   = 12;
    localparam int KEY_W   = 10;
    localparam int POS_W   = 10;
    localparam int GAIN_W  = 12;
    localparam int DELTA_W = 10;

    localparam int DEFAULT_SCREEN_WIDTH  = 320;
    localparam int DEFAULT_SCREEN_HEIGHT = 240;

    localparam logic [GAIN_W-1:0] GAIN_MIN = 12'd26;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 12'd2560;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 12'd256;

    // Key bit that carries the click button.
    localparam int KEY_CLICK = 1;

    // Reciprocal of ten in Q16, exact for magnitudes up to 4095.
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int          DIV10_SHIFT = 16;

    typedef struct packed {
        logic [PAD_W-1:0] pad_x;
        logic [PAD_W-1:0] pad_y;
        logic             pad_contact;
        logic             pad_clicked;
        logic [KEY_W-1:0] key_bits;
    } scan_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      button_down;
        logic [KEY_W-1:0]          press_edges;
        logic [KEY_W-1:0]          release_edges;
        logic                      moved;
    } motion_t;

    // Signed difference divided by ten, truncated toward zero.
    function automatic logic signed [DELTA_W-1:0] div10_trunc(input logic signed [PAD_W:0] d);
        logic [PAD_W-1:0] mag;
        logic [24:0]      prod;
        logic [8:0]       q;
        mag  = d[PAD_W] ? PAD_W'(-d) : d[PAD_W-1:0];
        prod = 25'(mag) * 25'(DIV10_RECIP);
        q    = prod[DIV10_SHIFT+8:DIV10_SHIFT];
        return d[PAD_W] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

endpackage

// ===== hdl/tpt_delta.sv =====
// Input stage and motion stage: key edges, touch tracking and the divided pad delta.
module tpt_delta
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpt_pkg::scan_t    scan,
    output logic              mot_valid,
    input  logic              mot_ready,
    output tpt_pkg::motion_t  mot
);

    logic                                 a_valid_reg;
    tpt_pkg::scan_t                       a_reg;
    logic                                 m_valid_reg;
    tpt_pkg::motion_t                     m_reg;
    logic [tpt_pkg::KEY_W-1:0]            prev_keys_reg;
    logic [tpt_pkg::PAD_W-1:0]            last_x_reg;
    logic [tpt_pkg::PAD_W-1:0]            last_y_reg;
    logic                                 last_touch_reg;

    logic                                 m_free;
    logic                                 a_adv;
    logic                                 touching;
    logic                                 use_motion;
    logic signed [tpt_pkg::PAD_W:0]       diff_x;
    logic signed [tpt_pkg::PAD_W:0]       diff_y;
    tpt_pkg::motion_t                     m_next;

    assign m_free   = !m_valid_reg || mot_ready;
    assign a_adv    = a_valid_reg && m_free;
    assign in_ready = !a_valid_reg || m_free;

    assign touching   = a_reg.pad_contact && !a_reg.pad_clicked;
    assign use_motion = touching && last_touch_reg;
    assign diff_x     = $signed({1'b0, a_reg.pad_x}) - $signed({1'b0, last_x_reg});
    assign diff_y     = $signed({1'b0, last_y_reg}) - $signed({1'b0, a_reg.pad_y});

    always_comb
    begin
        m_next.dx            = use_motion ? tpt_pkg::div10_trunc(diff_x) : '0;
        m_next.dy            = use_motion ? tpt_pkg::div10_trunc(diff_y) : '0;
        m_next.button_down   = a_reg.key_bits[tpt_pkg::KEY_CLICK];
        m_next.press_edges   = a_reg.key_bits & ~prev_keys_reg;
        m_next.release_edges = prev_keys_reg & ~a_reg.key_bits;
        m_next.moved         = (m_next.dx != '0) || (m_next.dy != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            prev_keys_reg  <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_touch_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (m_free)
            begin
                m_valid_reg <= a_valid_reg;
            end
            if (a_adv)
            begin
                prev_keys_reg  <= a_reg.key_bits;
                last_touch_reg <= touching;
                if (touching)
                begin
                    last_x_reg <= a_reg.pad_x;
                    last_y_reg <= a_reg.pad_y;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg <= scan;
        end
        if (a_adv)
        begin
            m_reg <= m_next;
        end
    end

    assign mot_valid = m_valid_reg;
    assign mot       = m_reg;

endmodule

// ===== hdl/tpt_axis.sv =====
// One cursor axis: gain multiply, accumulate and clamp to the screen.
module tpt_axis
#(
    parameter int LIMIT     = tpt_pkg::DEFAULT_SCREEN_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic signed [tpt_pkg::DELTA_W-1:0]  delta,
    input  logic [tpt_pkg::GAIN_W-1:0]          gain,
    output logic [tpt_pkg::POS_W-1:0]           pos
);

    localparam logic [tpt_pkg::POS_W-1:0] RESET_POS = tpt_pkg::POS_W'(LIMIT / 2);
    localparam logic [tpt_pkg::POS_W-1:0] LAST_POS  = tpt_pkg::POS_W'(LIMIT - 1);
    localparam logic [14:0]               LIM       = 15'(LIMIT);

    logic [tpt_pkg::POS_W-1:0]  pos_reg;
    logic [tpt_pkg::POS_W-1:0]  pos_next;
    logic signed [22:0]         prod;
    logic signed [23:0]         sum;
    logic [14:0]                whole;

    assign prod  = delta * $signed({1'b0, gain});
    assign sum   = $signed({6'b0, pos_reg, 8'b0}) + $signed({prod[22], prod});
    assign whole = sum[22:8];

    always_comb
    begin
        priority if (sum[23])
        begin
            pos_next = '0;
        end
        else if (whole >= LIM)
        begin
            pos_next = LAST_POS;
        end
        else
        begin
            pos_next = whole[tpt_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= RESET_POS;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

// ===== hdl/touchpad_pointer_tracker.sv =====
// Top level of the touchpad pointer tracker: gain register, cursor axes and result register.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------------------
//  input    in_valid / in_ready    pad_x, pad_y, pad_contact, pad_clicked, key_bits
//  result   out_valid / out_ready  cursor_x, cursor_y, button_down, press_edges,
//                                  release_edges, moved, any_event
//  config   cfg_valid / cfg_ready  cfg_data (sensitivity in Q4.8)
//
// Every scan item passes three registers in order: the input register, the motion register
// with the divided pad delta, and the result register with the cursor. One item is accepted
// per cycle while the result side keeps draining; the touch tracking state and the cursor
// state each live in their own stage, so consecutive items see each other's updates in time.
// Reset clears the pipeline, sets the gain to 1.0 and centers the cursor. When the
// result is not taken, each stage holds its item and ready falls back stage by stage,
// so a stage with a free slot still takes an item. cfg_ready is always high.
module touchpad_pointer_tracker
#(
    parameter int SCREEN_WIDTH  = tpt_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tpt_pkg::DEFAULT_SCREEN_HEIGHT
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tpt_pkg::PAD_W-1:0]   pad_x,
    input  logic [tpt_pkg::PAD_W-1:0]   pad_y,
    input  logic                        pad_contact,
    input  logic                        pad_clicked,
    input  logic [tpt_pkg::KEY_W-1:0]   key_bits,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tpt_pkg::POS_W-1:0]   cursor_x,
    output logic [tpt_pkg::POS_W-1:0]   cursor_y,
    output logic                        button_down,
    output logic [tpt_pkg::KEY_W-1:0]   press_edges,
    output logic [tpt_pkg::KEY_W-1:0]   release_edges,
    output logic                        moved,
    output logic                        any_event,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tpt_pkg::GAIN_W-1:0]  cfg_data
);

    // Gain register. A written value saturates into the legal range of 0.1 to 10.0.
    logic [tpt_pkg::GAIN_W-1:0]  gain_reg;
    logic [tpt_pkg::GAIN_W-1:0]  gain_next;

    // Result handshake and the registered result fields. The cursor fields come straight
    // from the axis position registers, which are updated on the same edge.
    logic                        out_valid_reg;
    logic                        button_reg;
    logic [tpt_pkg::KEY_W-1:0]   press_reg;
    logic [tpt_pkg::KEY_W-1:0]   release_reg;
    logic                        moved_reg;
    logic                        event_reg;

    tpt_pkg::scan_t              scan;
    tpt_pkg::motion_t            mot;
    logic                        mot_valid;
    logic                        mot_ready;
    logic                        mot_adv;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (cfg_data > tpt_pkg::GAIN_MAX)
        begin
            gain_next = tpt_pkg::GAIN_MAX;
        end
        else if (cfg_data < tpt_pkg::GAIN_MIN)
        begin
            gain_next = tpt_pkg::GAIN_MIN;
        end
        else
        begin
            gain_next = cfg_data;
        end
    end

    assign scan.pad_x       = pad_x;
    assign scan.pad_y       = pad_y;
    assign scan.pad_contact = pad_contact;
    assign scan.pad_clicked = pad_clicked;
    assign scan.key_bits    = key_bits;

    // The result register can load whenever it is empty or being drained this cycle.
    assign mot_ready = !out_valid_reg || out_ready;
    assign mot_adv   = mot_valid && mot_ready;

    tpt_delta u_delta
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .scan      (scan),
        .mot_valid (mot_valid),
        .mot_ready (mot_ready),
        .mot       (mot)
    );

    // Screen Y grows downward, so the motion stage already inverted the pad Y delta.
    tpt_axis #(.LIMIT(SCREEN_WIDTH)) u_axis_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (mot_adv),
        .delta (mot.dx),
        .gain  (gain_reg),
        .pos   (cursor_x)
    );

    tpt_axis #(.LIMIT(SCREEN_HEIGHT)) u_axis_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (mot_adv),
        .delta (mot.dy),
        .gain  (gain_reg),
        .pos   (cursor_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= tpt_pkg::GAIN_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= gain_next;
            end
            if (mot_ready)
            begin
                out_valid_reg <= mot_valid;
            end
        end
    end

    // Movement or a click press or release counts as an event; other key edges are reported
    // in the edge vectors but do not raise the event flag.
    always_ff @(posedge clk)
    begin
        if (mot_adv)
        begin
            button_reg  <= mot.button_down;
            press_reg   <= mot.press_edges;
            release_reg <= mot.release_edges;
            moved_reg   <= mot.moved;
            event_reg   <= mot.moved || mot.press_edges[tpt_pkg::KEY_CLICK]
                           || mot.release_edges[tpt_pkg::KEY_CLICK];
        end
    end

    assign out_valid     = out_valid_reg;
    assign button_down   = button_reg;
    assign press_edges   = press_reg;
    assign release_edges = release_reg;
    assign moved         = moved_reg;
    assign any_event     = event_reg;

endmodule
